FILE: sv/qrs_pkg.sv
// qrs_pkg: widths and the status code type for the quadratic root solver.
// No dependencies.
`default_nettype none
package qrs_pkg;
    localparam int unsigned CW   = 16;
    localparam int unsigned FB   = 8;
    localparam int unsigned DW   = 2 * CW + 2;       // discriminant width (magnitude)
    localparam int unsigned SW   = CW + 1;           // sqrt width
    localparam int unsigned NW   = CW + 2 + FB;      // numerator magnitude width
    localparam int unsigned QW   = NW;               // quotient magnitude width
    localparam int unsigned KW   = CW + 1;           // |2a| width

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_NONE   = 2'd2,
        ST_AZERO  = 2'd3
    } t_status;
endpackage
`default_nettype wire

FILE: sv/qrs_if.sv
// qrs_if: valid/ready request channel carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface qrs_if #(parameter int W = 48) (input wire logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/qrs_sqrt.sv
// qrs_sqrt: pipelined restoring square root, one result digit per stage.
// Depends on nothing. Side data travels alongside; stall by i_en.
`default_nettype none
module qrs_sqrt #(
    parameter int DW = 34,
    parameter int RW = 17,
    parameter int XW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [DW-1:0] i_rad,
    input  wire logic [XW-1:0] i_side,
    output logic               o_vld,
    output logic [RW-1:0]      o_root,
    output logic [XW-1:0]      o_side
);
    localparam int PW = 2 * RW;
    logic [RW:0]   r_vld;
    logic [PW-1:0] r_rad [RW+1];
    logic [RW+1:0] r_rem [RW+1];
    logic [RW-1:0] r_root [RW+1];
    logic [XW-1:0] r_side [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= PW'(i_rad);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [RW+1:0] w_rem, w_trial;
        always_comb begin
            w_rem   = {r_rem[g][RW-1:0], r_rad[g][PW-1 -: 2]};
            w_trial = {r_root[g], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g+1]  <= {r_rad[g][PW-3:0], 2'b00};
                r_side[g+1] <= r_side[g];
                if (w_rem >= w_trial) begin
                    r_rem[g+1]  <= w_rem - w_trial;
                    r_root[g+1] <= {r_root[g][RW-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= w_rem;
                    r_root[g+1] <= {r_root[g][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_side = r_side[RW];
endmodule
`default_nettype wire

FILE: sv/qrs_div.sv
// qrs_div: pipelined restoring divider for two unsigned numerators over one divisor.
// Depends on nothing. One quotient bit per stage for both lanes.
`default_nettype none
module qrs_div #(
    parameter int NW = 26,
    parameter int KW = 17,
    parameter int XW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num_p,
    input  wire logic [NW-1:0] i_num_m,
    input  wire logic [KW-1:0] i_den,
    input  wire logic [XW-1:0] i_side,
    output logic               o_vld,
    output logic [NW-1:0]      o_q_p,
    output logic [NW-1:0]      o_q_m,
    output logic [XW-1:0]      o_side
);
    logic [NW:0]   r_vld;
    logic [NW-1:0] r_np [NW+1];
    logic [NW-1:0] r_nm [NW+1];
    logic [KW:0]   r_rp [NW+1];
    logic [KW:0]   r_rm [NW+1];
    logic [KW-1:0] r_den [NW+1];
    logic [XW-1:0] r_side [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_np[0]   <= i_num_p;
            r_nm[0]   <= i_num_m;
            r_rp[0]   <= '0;
            r_rm[0]   <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // numerator register shifts out its top bit and collects quotient bits at the bottom
    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [KW:0] w_tp, w_tm;
        always_comb begin
            w_tp = {r_rp[g][KW-1:0], r_np[g][NW-1]};
            w_tm = {r_rm[g][KW-1:0], r_nm[g][NW-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
                if (w_tp >= {1'b0, r_den[g]}) begin
                    r_rp[g+1] <= w_tp - {1'b0, r_den[g]};
                    r_np[g+1] <= {r_np[g][NW-2:0], 1'b1};
                end else begin
                    r_rp[g+1] <= w_tp;
                    r_np[g+1] <= {r_np[g][NW-2:0], 1'b0};
                end
                if (w_tm >= {1'b0, r_den[g]}) begin
                    r_rm[g+1] <= w_tm - {1'b0, r_den[g]};
                    r_nm[g+1] <= {r_nm[g][NW-2:0], 1'b1};
                end else begin
                    r_rm[g+1] <= w_tm;
                    r_nm[g+1] <= {r_nm[g][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[NW];
    assign o_q_p  = r_np[NW];
    assign o_q_m  = r_nm[NW];
    assign o_side = r_side[NW];
endmodule
`default_nettype wire

FILE: sv/quadratic_root_solver_core.sv
// quadratic_root_solver_core: real roots of a*x^2+b*x+c in signed fixed point.
// Depends on qrs_pkg, qrs_if, qrs_sqrt, qrs_div.
//
//  channel   dir  payload {msb..lsb}
//  i_coef    in   coef_c, coef_b, coef_a   (3 x 16, signed Q8.8)
//  o_root    out  saturated, root_minus, root_plus, status
//
// One request accepted per cycle unless the pipe stalls; a result passes the product
// and discriminant registers, the one-digit-per-stage square root pipe, the numerator
// register, the one-bit-per-stage divider pipe and the output register.
// Whole pipe advances together; it stalls only when the output register is full
// and not taken. Synchronous active-low reset clears the valid bits only.
`default_nettype none
module quadratic_root_solver_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qrs_if.sink       i_coef,
    qrs_if.source     o_root
);
    import qrs_pkg::*;
    localparam int RW = DW / 2;
    localparam int XW = 2 + CW + 1;  // status, two quotient signs, zero padding

    logic w_en;
    assign w_en = !o_root.valid || o_root.ready;
    assign i_coef.ready = w_en;

    logic signed [CW-1:0] w_a, w_b, w_c;
    assign w_a = i_coef.data[CW-1:0];
    assign w_b = i_coef.data[2*CW-1:CW];
    assign w_c = i_coef.data[3*CW-1:2*CW];

    // unsigned magnitudes; |-2^(CW-1)| fits in CW bits
    logic [CW-1:0] w_ma, w_mb, w_mc;
    assign w_ma = w_a[CW-1] ? CW'(-w_a) : CW'(w_a);
    assign w_mb = w_b[CW-1] ? CW'(-w_b) : CW'(w_b);
    assign w_mc = w_c[CW-1] ? CW'(-w_c) : CW'(w_c);

    // stage 1: products
    logic                 r1_vld;
    logic [2*CW-1:0]      r1_p, r1_q;
    logic                 r1_qneg, r1_az;
    logic signed [CW-1:0] r1_a, r1_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (w_en) r1_vld <= i_coef.valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p    <= w_mb * w_mb;
            r1_q    <= w_ma * w_mc;
            r1_qneg <= w_a[CW-1] ^ w_c[CW-1];
            r1_az   <= w_a == '0;
            r1_a    <= w_a;
            r1_b    <= w_b;
        end
    end

    // stage 2: discriminant and status
    logic [DW-1:0] w_sum, w_dif, w_4q;
    logic          w_pos;
    assign w_4q  = {r1_q, 2'b00};
    assign w_sum = DW'(r1_p) + w_4q;
    assign w_dif = DW'(r1_p) - w_4q;
    logic          r2_vld;
    logic [DW-1:0] r2_d;
    t_status       r2_st;
    logic [CW:0]   r2_nb;
    logic [CW:0]   r2_a2;
    always_comb begin
        w_pos = r1_qneg || r1_q == '0;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (w_en) r2_vld <= r1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_nb <= -{r1_b[CW-1], r1_b};
            r2_a2 <= {r1_a, 1'b0};
            priority if (r1_az) begin
                r2_st <= ST_AZERO;
                r2_d  <= '0;
            end else if (w_pos) begin
                r2_st <= (w_sum == '0) ? ST_DOUBLE : ST_TWO;
                r2_d  <= w_sum;
            end else if (DW'(r1_p) > w_4q) begin
                r2_st <= ST_TWO;
                r2_d  <= w_dif;
            end else if (DW'(r1_p) == w_4q) begin
                r2_st <= ST_DOUBLE;
                r2_d  <= '0;
            end else begin
                r2_st <= ST_NONE;
                r2_d  <= '0;
            end
        end
    end

    logic          w_s_vld;
    logic [RW-1:0] w_s;
    logic [CW+1+CW+1+2-1:0] w_s_side;
    qrs_sqrt #(.DW(DW), .RW(RW), .XW(2*CW+4)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r2_vld),
        .i_rad(r2_d), .i_side({r2_st, r2_nb, r2_a2}),
        .o_vld(w_s_vld), .o_root(w_s), .o_side(w_s_side)
    );

    // stage 3: signed numerators, magnitudes for the divider
    t_status              w_s_st;
    logic signed [CW:0]   w_s_nb, w_s_a2;
    logic signed [RW+1:0] w_np, w_nm;
    assign w_s_st = t_status'(w_s_side[2*CW+3 -: 2]);
    assign w_s_nb = w_s_side[2*CW+1 -: CW+1];
    assign w_s_a2 = w_s_side[CW:0];
    assign w_np = (RW+2)'(w_s_nb) + (RW+2)'($signed({1'b0, w_s}));
    assign w_nm = (RW+2)'(w_s_nb) - (RW+2)'($signed({1'b0, w_s}));

    logic          r3_vld;
    logic [NW-1:0] r3_mp, r3_mm;
    logic [KW-1:0] r3_den;
    logic [XW-1:0] r3_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (w_en) r3_vld <= w_s_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_mp   <= NW'({(w_np[RW+1] ? -w_np : w_np), FB'(0)});
            r3_mm   <= NW'({(w_nm[RW+1] ? -w_nm : w_nm), FB'(0)});
            r3_den  <= w_s_a2[CW] ? KW'(-w_s_a2) : KW'(w_s_a2);
            // sign of each quotient: numerator sign xor denominator sign
            r3_side <= {w_s_st, w_np[RW+1] ^ w_s_a2[CW], w_nm[RW+1] ^ w_s_a2[CW],
                        {(CW-1){1'b0}}};
        end
    end

    logic          w_q_vld;
    logic [NW-1:0] w_qp, w_qm;
    logic [XW-1:0] w_q_side;
    qrs_div #(.NW(NW), .KW(KW), .XW(XW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r3_vld),
        .i_num_p(r3_mp), .i_num_m(r3_mm), .i_den(r3_den), .i_side(r3_side),
        .o_vld(w_q_vld), .o_q_p(w_qp), .o_q_m(w_qm), .o_side(w_q_side)
    );

    // clamp and output register
    localparam logic [NW-1:0] MAXP = NW'((1 << (CW-1)) - 1);
    localparam logic [NW-1:0] MAXN = NW'(1 << (CW-1));
    t_status       w_f_st;
    logic          w_sgp, w_sgm, w_satp, w_satm, w_live;
    logic [CW-1:0] w_rp, w_rm;
    assign w_f_st = t_status'(w_q_side[XW-1 -: 2]);
    assign w_sgp  = w_q_side[XW-3];
    assign w_sgm  = w_q_side[XW-4];
    assign w_live = (w_f_st == ST_TWO) || (w_f_st == ST_DOUBLE);
    always_comb begin
        w_satp = w_sgp ? (w_qp > MAXN) : (w_qp > MAXP);
        w_satm = w_sgm ? (w_qm > MAXN) : (w_qm > MAXP);
        if (w_satp) w_rp = w_sgp ? CW'(MAXN) : CW'(MAXP);
        else        w_rp = w_sgp ? CW'(-w_qp) : CW'(w_qp);
        if (w_satm) w_rm = w_sgm ? CW'(MAXN) : CW'(MAXP);
        else        w_rm = w_sgm ? CW'(-w_qm) : CW'(w_qm);
    end

    logic r_ovld;
    logic [2*CW+2:0] r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (w_en) r_ovld <= w_q_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata <= w_live ? {w_satp | w_satm, w_rm, w_rp, w_f_st}
                              : {1'b0, {CW{1'b0}}, {CW{1'b0}}, w_f_st};
        end
    end
    assign o_root.valid = r_ovld;
    assign o_root.data  = r_odata;

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !o_root.ready |=> r_ovld && $stable(r_odata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_coef.ready == (!r_ovld || o_root.ready))
        else $error("input ready not tied to output slot");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && (r_odata[1:0] == ST_NONE || r_odata[1:0] == ST_AZERO)
        |-> r_odata[2*CW+2:2] == '0)
        else $error("roots not zero without real roots");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_quadratic_root_solver_core.sv
// tb_quadratic_root_solver_core: checks the quadratic root solver against its own predictor.
// Drives coefficient requests through qrs_if, compares every result field by field.
// Depends on qrs_pkg, qrs_if and quadratic_root_solver_core.
`timescale 1ns / 1ps
`default_nettype none
module tb_quadratic_root_solver_core;
    import qrs_pkg::*;

    localparam int unsigned OUT_W = 2 + 2 * CW + 1;
    localparam int unsigned NUM_RANDOM = 530;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic            saturated;
        logic [CW-1:0]   root_minus;
        logic [CW-1:0]   root_plus;
        t_status         status;
    } t_roots;

    typedef struct {
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] c;
        bit            known;
        t_roots        want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    qrs_if #(.W(3 * CW)) coef_ch (.i_clk(i_clk));
    qrs_if #(.W(OUT_W))  root_ch (.i_clk(i_clk));

    quadratic_root_solver_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_coef (coef_ch.sink),
        .o_root (root_ch.source)
    );

    t_roots      roots_due[$];
    int          n_fail = 0;
    int          n_checked = 0;
    longint      n_cycles = 0;
    int          send_idle_pct = 6;
    int          recv_idle_pct = 87;
    int          n_status[4] = '{0, 0, 0, 0};
    int          n_sat = 0;

    function automatic logic [65:0] isqrt_floor(logic [65:0] d);
        logic [65:0] rem;
        logic [65:0] root;
        logic [65:0] trial;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | ((d >> (2 * i)) & 66'd3);
            trial = (root << 2) | 66'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 66'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic [CW-1:0] clamp_q(longint v, ref logic sat);
        longint hi;
        longint lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi[CW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic t_roots solve_roots(logic [CW-1:0] ra, logic [CW-1:0] rb,
                                           logic [CW-1:0] rc);
        t_roots r;
        longint a;
        longint b;
        longint c;
        logic signed [67:0] disc;
        longint s;
        longint den;
        logic sat;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        c = longint'($signed(rc));
        r = '0;
        sat = 1'b0;
        if (a == 0) begin
            r.status = ST_AZERO;
        end else begin
            disc = 68'(b * b) - 68'sd4 * 68'(a * c);
            if (disc < 0) begin
                r.status = ST_NONE;
            end else begin
                s = longint'(isqrt_floor(disc[65:0]));
                den = 2 * a;
                r.status = (disc == 0) ? ST_DOUBLE : ST_TWO;
                r.root_plus = clamp_q(((-b + s) * (longint'(1) << FB)) / den, sat);
                r.root_minus = clamp_q(((-b - s) * (longint'(1) << FB)) / den, sat);
                r.saturated = sat;
            end
        end
        return r;
    endfunction

    // directed requests; expected result typed in only where obvious
    function automatic t_row mk(int a, int b, int c, bit known = 0,
                                t_status st = ST_TWO, int rp = 0, int rm = 0,
                                bit sat = 0);
        t_row r;
        r.a = a[CW-1:0];
        r.b = b[CW-1:0];
        r.c = c[CW-1:0];
        r.known = known;
        r.want.status = st;
        r.want.root_plus = rp[CW-1:0];
        r.want.root_minus = rm[CW-1:0];
        r.want.saturated = sat;
        return r;
    endfunction

    t_row directed[$];

    initial begin
        directed.push_back(mk(0, 0, 0, 1, ST_AZERO));
        directed.push_back(mk(0, -32768, 32767, 1, ST_AZERO));
        directed.push_back(mk(0, 32767, -32768, 1, ST_AZERO));
        directed.push_back(mk(256, 0, 256, 1, ST_NONE));
        directed.push_back(mk(-32768, 0, -32768, 1, ST_NONE));
        directed.push_back(mk(256, 0, 0, 1, ST_DOUBLE, 0, 0));
        directed.push_back(mk(256, -512, 256, 1, ST_DOUBLE, 256, 256));
        directed.push_back(mk(256, 0, -256, 1, ST_TWO, 256, -256));
        directed.push_back(mk(1, 32767, 0, 1, ST_TWO, 0, -32768, 1));
        directed.push_back(mk(-1, -32768, 0));
        directed.push_back(mk(32767, 32767, 32767));
        directed.push_back(mk(-32768, -32768, -32768));
        directed.push_back(mk(-32768, -32768, 32767));
        directed.push_back(mk(32767, -32768, -32768));
        directed.push_back(mk(-32768, 32767, 32767));
        directed.push_back(mk(1, -32768, -32768));
        directed.push_back(mk(-1, 1, 32767));
        directed.push_back(mk(1, 1, 1));
        directed.push_back(mk(-256, 768, -512));
        directed.push_back(mk(512, -1280, 512));
        directed.push_back(mk(-21846, -21846, 21845));
        directed.push_back(mk(21845, 21845, -21846));
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_quadratic_root_solver_core: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            root_ch.ready <= 1'b0;
        else
            root_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_roots got;
        t_roots want;
        if (i_rst_n && root_ch.valid && root_ch.ready) begin
            got = t_roots'(root_ch.data);
            if (roots_due.size() == 0) begin
                $error("unexpected result %h", got);
                n_fail++;
            end else begin
                want = roots_due.pop_front();
                n_checked++;
                n_status[got.status]++;
                if (got.saturated)
                    n_sat++;
                if (got.status !== want.status) begin
                    $error("status: expected %s, got %0d", want.status.name(), got.status);
                    n_fail++;
                end
                if (got.root_plus !== want.root_plus) begin
                    $error("root_plus: expected %0d, got %0d",
                           $signed(want.root_plus), $signed(got.root_plus));
                    n_fail++;
                end
                if (got.root_minus !== want.root_minus) begin
                    $error("root_minus: expected %0d, got %0d",
                           $signed(want.root_minus), $signed(got.root_minus));
                    n_fail++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, got.saturated);
                    n_fail++;
                end
            end
        end
    end

    task automatic send_request(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                                bit known, t_roots want);
        while ($urandom_range(99) < send_idle_pct) begin
            coef_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        coef_ch.valid <= 1'b1;
        coef_ch.data <= {c, b, a};
        if (known && want !== solve_roots(a, b, c)) begin
            $error("request table row disagrees with predictor: %h", want);
            n_fail++;
        end
        @(posedge i_clk);
        while (!coef_ch.ready)
            @(posedge i_clk);
        roots_due.push_back(known ? want : solve_roots(a, b, c));
        @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(5))
            0: return CW'($urandom_range(15)) - CW'(8);
            1: return CW'($urandom_range(2047)) - CW'(1024);
            2: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($urandom);
        endcase
    endfunction

    initial begin
        logic [CW-1:0] ra;
        logic [CW-1:0] rb;
        logic [CW-1:0] rc;
        t_roots none;
        none = '0;
        coef_ch.valid = 1'b0;
        coef_ch.data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 87 : 0;
            recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 6 : 0;
            if (phase == 0) begin
                foreach (directed[i])
                    send_request(directed[i].a, directed[i].b, directed[i].c,
                                 directed[i].known, directed[i].want);
            end
            for (int n = 0; n < NUM_RANDOM / 3; n++) begin
                ra = rand_coef();
                rb = rand_coef();
                rc = rand_coef();
                // steer some requests onto a real double root: b = 2k, a*c = k*k
                if ($urandom_range(7) == 0) begin
                    ra = CW'($urandom_range(255)) - CW'(128);
                    rc = ra;
                    rb = CW'(2) * ra;
                end
                send_request(ra, rb, rc, 0, none);
            end
        end
        coef_ch.valid <= 1'b0;
        while (roots_due.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("checked %0d results: two %0d, double %0d, none %0d, a zero %0d",
                 n_checked, n_status[0], n_status[1], n_status[2], n_status[3]);
        $display("%0d results clamped, over three sender/receiver idling phases", n_sat);
        if (n_fail == 0)
            $display("tb_quadratic_root_solver_core: PASS");
        else
            $display("tb_quadratic_root_solver_core: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
sv/qrs_pkg.sv
sv/qrs_if.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver_core.sv
tb/tb_quadratic_root_solver_core.sv
